FILE: design/fgbt_pkg.sv
// package: shared types and request codes for the gain bucket table
package fgbt_pkg;
    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_UPDATE = 3'd1,
        REQ_POP    = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_LOCK   = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_POPHD,
        ST_POPRD,
        ST_UNLINK,
        ST_UNLINK_N,
        ST_FILE_HD,
        ST_FILE,
        ST_FILE_N,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] vertex;
        logic       side;
        logic [7:0] gain_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0] best_vertex;
        logic [6:0] best_gain;
        logic       found;
        logic       left_empty;
        logic       right_empty;
    } t_out_item;
endpackage

FILE: design/fgbt_if.sv
// interface: valid/ready channel carrying one payload
interface fgbt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/fm_gain_bucket_table_unit.sv
// top level: two-sided gain bucket table with linked lists held in memories
//
// usage: one request transaction enters on i_req (insert, update, pop best,
// erase, lock) and exactly one result transaction leaves on o_res.
// the block handles one request at a time: i_req.ready is high only in idle.
// a lock or an ignored request goes straight to the result; a pop scans the
// bucket bits of its side from the highest gain down, over up to
// 2*MAX_GAIN+1 buckets. the block returns to idle once the result is loaded.
// vertex memory (gain, side, links, locked, filed) and bucket head memory
// each have registered read data; only the bucket nonempty bits are flops.
// reset: a clearing pass over all 1024 vertex entries clears the locked and filed flags,
// i_req.ready stays low meanwhile; all buckets start empty.
// stall: a result waits in the output register until o_res.ready; the next
// request is still taken, and its result waits until the register is free.
module fm_gain_bucket_table_unit #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_GAIN     = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fgbt_if.sink   i_req,
    fgbt_if.source o_res
);
    import fgbt_pkg::*;

    localparam int SPAN = 2 * MAX_GAIN + 1;
    localparam int NB   = 2 * SPAN;
    localparam int BW   = $clog2(NB);
    localparam int VD   = 1024;
    localparam int GW   = $clog2(MAX_GAIN + 1) + 1;
    localparam int EW   = ((GW > 8) ? GW : 8) + 1;
    localparam int SW   = $clog2(SPAN);

    // vertex memory fields, indexed by the 10-bit vertex number
    logic [GW-1:0] m_gain  [VD];
    logic [9:0]    m_next  [VD];
    logic [9:0]    m_prev  [VD];
    logic          m_side  [VD];
    logic          m_lock  [VD];
    logic          m_filed [VD];
    // bucket head memory
    logic [9:0]    m_head  [NB];
    logic [NB-1:0] r_ne;

    t_state r_st, n_st;
    t_in_item r_in;
    t_out_item r_out;
    logic r_ov;
    logic [9:0]    r_clr;
    logic [9:0]    r_v, r_p, r_n;
    logic [GW-1:0] r_g;
    logic          r_vs;
    logic [SW-1:0] r_scan;
    logic          r_refile;
    logic          r_scan_hit;
    logic [9:0]    rd_addr;
    logic [GW-1:0] rd_gain;
    logic [9:0]    rd_next, rd_prev;
    logic          rd_side, rd_lock, rd_filed;
    logic [BW-1:0] hd_addr;
    logic [9:0]    hd_q;

    wire vok = (r_in.vertex != 10'd0) && (32'(r_in.vertex) < MAX_VERTICES);

    function automatic logic [GW-1:0] clampg(input logic signed [EW-1:0] g);
        if (g > EW'(MAX_GAIN)) return GW'(MAX_GAIN);
        if (g < -EW'(MAX_GAIN)) return GW'(-MAX_GAIN);
        return GW'(g);
    endfunction

    function automatic logic [BW-1:0] bidx(input logic s, input logic [GW-1:0] g);
        return BW'(s ? SPAN : 0) + BW'($signed(g) + MAX_GAIN);
    endfunction

    wire [BW-1:0] scan_b = BW'(r_in.side ? SPAN : 0) + BW'(r_scan);
    wire [BW-1:0] ub = bidx(r_vs, r_g);
    logic signed [EW-1:0] newg;
    always_comb begin
        if (r_in.req_type == REQ_INSERT)
            newg = EW'($signed(r_in.gain_value));
        else
            newg = EW'($signed(r_g)) + EW'($signed(r_in.gain_value));
    end
    wire [GW-1:0] fg = (r_refile && r_in.req_type != REQ_POP) ? clampg(newg) : r_g;
    wire [BW-1:0] fb = bidx(r_in.side, fg);

    // read ports, registered data
    always_ff @(posedge i_clk) begin
        rd_gain  <= m_gain[rd_addr];
        rd_next  <= m_next[rd_addr];
        rd_prev  <= m_prev[rd_addr];
        rd_side  <= m_side[rd_addr];
        rd_lock  <= m_lock[rd_addr];
        rd_filed <= m_filed[rd_addr];
        hd_q     <= m_head[hd_addr];
    end

    assign i_req.ready = (r_st == ST_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    // vertex read: request vertex at accept, bucket head during a pop
    always_comb begin
        rd_addr = r_in.vertex;
        if (r_st == ST_IDLE) rd_addr = i_req.data.vertex;
        if (r_st == ST_POPHD) rd_addr = hd_q;
    end

    // head read: scanned bucket, or target bucket before filing
    always_comb begin
        hd_addr = scan_b;
        if (r_st == ST_FILE_HD) hd_addr = fb;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLR:   if (r_clr == 10'h3FF) n_st = ST_IDLE;
            ST_IDLE:  if (i_req.valid && i_req.ready) n_st = ST_RD;
            ST_RD: begin
                priority case (1'b1)
                    r_in.req_type == REQ_POP: n_st = ST_SCAN;
                    !vok: n_st = ST_OUT;
                    r_in.req_type == REQ_INSERT:
                        n_st = rd_filed ? ST_UNLINK : ST_FILE_HD;
                    r_in.req_type == REQ_UPDATE || r_in.req_type == REQ_ERASE:
                        n_st = (!rd_lock && rd_filed) ? ST_UNLINK : ST_OUT;
                    default: n_st = ST_OUT;
                endcase
            end
            ST_SCAN: begin
                if (r_ne[scan_b]) n_st = ST_POPHD;
                else if (r_scan == '0) n_st = ST_OUT;
            end
            ST_POPHD:    n_st = ST_POPRD;
            ST_POPRD:    n_st = ST_UNLINK;
            ST_UNLINK:   n_st = ST_UNLINK_N;
            ST_UNLINK_N: n_st = r_refile ? ST_FILE_HD : ST_OUT;
            ST_FILE_HD:  n_st = ST_FILE;
            ST_FILE:     n_st = ST_FILE_N;
            ST_FILE_N:   n_st = ST_OUT;
            ST_OUT:      n_st = (!r_ov || o_res.ready) ? ST_IDLE : ST_OUT;
            default:     n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR;
            r_clr <= '0;
            r_ov <= 1'b0;
            r_ne <= '0;
        end else begin
            r_st <= n_st;
            // output register: load when free or being emptied
            if (r_st == ST_OUT && (!r_ov || o_res.ready)) r_ov <= 1'b1;
            else if (r_ov && o_res.ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_CLR: begin
                    m_lock[r_clr] <= 1'b0;
                    m_filed[r_clr] <= 1'b0;
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: if (i_req.valid && i_req.ready) begin
                    r_in <= i_req.data;
                    r_scan <= SW'(SPAN - 1);
                end
                ST_RD: begin
                    r_v <= r_in.vertex; r_g <= rd_gain; r_p <= rd_prev;
                    r_n <= rd_next; r_vs <= rd_side;
                    r_refile <= (r_in.req_type == REQ_INSERT)
                              || (r_in.req_type == REQ_UPDATE);
                    if (vok && r_in.req_type == REQ_LOCK)
                        m_lock[r_in.vertex] <= 1'b1;
                    if (vok && r_in.req_type == REQ_INSERT)
                        m_lock[r_in.vertex] <= 1'b0;
                end
                ST_SCAN: begin
                    if (!r_ne[scan_b]) r_scan <= r_scan - 1'b1;
                end
                ST_POPHD: r_v <= hd_q;
                ST_POPRD: begin
                    r_g <= rd_gain; r_p <= rd_prev; r_n <= rd_next;
                    r_vs <= rd_side; r_refile <= 1'b0;
                end
                ST_UNLINK: begin
                    if (r_p != 10'd0) m_next[r_p] <= r_n;
                    else m_head[ub] <= r_n;
                    if (r_p == 10'd0 && r_n == 10'd0) r_ne[ub] <= 1'b0;
                    m_filed[r_v] <= 1'b0;
                end
                ST_UNLINK_N: begin
                    if (r_n != 10'd0) m_prev[r_n] <= r_p;
                    if (r_in.req_type == REQ_POP) m_lock[r_v] <= 1'b1;
                end
                ST_FILE_HD: ;
                ST_FILE: begin
                    r_n <= r_ne[fb] ? hd_q : 10'd0;
                    m_next[r_v] <= r_ne[fb] ? hd_q : 10'd0;
                    m_prev[r_v] <= 10'd0;
                    m_gain[r_v] <= fg;
                    m_side[r_v] <= r_in.side;
                    m_head[fb] <= r_v;
                    r_ne[fb] <= 1'b1;
                    m_filed[r_v] <= 1'b1;
                end
                ST_FILE_N: if (r_n != 10'd0) m_prev[r_n] <= r_v;
                ST_OUT: if (!r_ov || o_res.ready) begin
                    r_out.found <= (r_in.req_type == REQ_POP) && r_scan_hit;
                    r_out.best_vertex <= (r_in.req_type == REQ_POP && r_scan_hit)
                                       ? r_v : 10'd0;
                    r_out.best_gain <= (r_in.req_type == REQ_POP && r_scan_hit)
                                     ? 7'($signed(r_g)) : 7'd0;
                    r_out.left_empty <= ~|r_ne[SPAN-1:0];
                    r_out.right_empty <= ~|r_ne[NB-1:SPAN];
                end
                default: ;
            endcase
        end
    end

    // pop hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scan_hit <= 1'b0;
        else if (r_st == ST_IDLE) r_scan_hit <= 1'b0;
        else if (r_st == ST_SCAN && r_ne[scan_b]) r_scan_hit <= 1'b1;
    end
endmodule

FILE: verif/fm_gain_bucket_table_unit_tb.sv
// testbench: drives requests into the gain bucket table and checks every result
module fm_gain_bucket_table_unit_tb;
    import fgbt_pkg::*;

    localparam int NV = 1024;
    localparam int GMAX = 63;
    localparam int SPAN = 2 * GMAX + 1;

    // mirror of the table and its checker
    class bucket_scoreboard;
        int gain_of[NV];
        bit locked[NV];
        bit filed[NV];
        bit side_of[NV];
        int nxt[NV];
        int prv[NV];
        int head[2*SPAN];
        bit busy[2*SPAN];
        t_out_item pending_results[$];
        int mismatches;

        function int clamp(int g);
            if (g > GMAX) return GMAX;
            if (g < -GMAX) return -GMAX;
            return g;
        endfunction

        function void unfile(int v);
            int b, p, n;
            b = side_of[v] * SPAN + gain_of[v] + GMAX;
            p = prv[v];
            n = nxt[v];
            if (p != 0) nxt[p] = n; else head[b] = n;
            if (n != 0) prv[n] = p;
            if (p == 0 && n == 0) busy[b] = 0;
            filed[v] = 0;
        endfunction

        function void file_at_front(int v, bit s);
            int b, n;
            b = s * SPAN + gain_of[v] + GMAX;
            n = busy[b] ? head[b] : 0;
            nxt[v] = n;
            prv[v] = 0;
            if (n != 0) prv[n] = v;
            head[b] = v;
            busy[b] = 1;
            filed[v] = 1;
            side_of[v] = s;
        endfunction

        function bit side_is_empty(bit s);
            for (int i = 0; i < SPAN; i++)
                if (busy[s*SPAN+i]) return 0;
            return 1;
        endfunction

        function bit is_filed(int v);
            return filed[v];
        endfunction

        // work out the result of one accepted request
        function void note_request(t_in_item it);
            t_out_item r;
            int v, g;
            bit ok;
            v = it.vertex;
            g = $signed(it.gain_value);
            ok = (v != 0);
            r = '0;
            case (it.req_type)
                REQ_INSERT: if (ok) begin
                    if (filed[v]) unfile(v);
                    locked[v] = 0;
                    gain_of[v] = clamp(g);
                    file_at_front(v, it.side);
                end
                REQ_UPDATE: if (ok && !locked[v] && filed[v]) begin
                    unfile(v);
                    gain_of[v] = clamp(gain_of[v] + g);
                    file_at_front(v, it.side);
                end
                REQ_POP: begin
                    for (int gg = GMAX; gg >= -GMAX; gg--) begin
                        if (busy[it.side*SPAN + gg + GMAX]) begin
                            int h;
                            h = head[it.side*SPAN + gg + GMAX];
                            unfile(h);
                            locked[h] = 1;
                            r.best_vertex = h;
                            r.best_gain = gg;
                            r.found = 1;
                            break;
                        end
                    end
                end
                REQ_ERASE: if (ok && !locked[v] && filed[v]) unfile(v);
                REQ_LOCK: if (ok) locked[v] = 1;
                default: ;
            endcase
            r.left_empty = side_is_empty(0);
            r.right_empty = side_is_empty(1);
            pending_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: vtx %0d/%0d gain %0d/%0d found %b/%b le %b/%b re %b/%b",
                        want.best_vertex, got.best_vertex, $signed(want.best_gain),
                        $signed(got.best_gain), want.found, got.found,
                        want.left_empty, got.left_empty, want.right_empty, got.right_empty);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    fgbt_if #(.T(t_in_item)) req_ch ();
    fgbt_if #(.T(t_out_item)) res_ch ();

    fm_gain_bucket_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    bucket_scoreboard table_mirror = new();
    bit no_idle = 0;   // long stretch with steady traffic on both sides
    int active_pool[$];  // vertices likely to be filed

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        res_ch.ready = 0;
    end

    // result side: random back pressure, check on each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            table_mirror.check_result(res_ch.data);
        res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_request(t_req rt, int v, bit s, int g);
        t_in_item it;
        while (!no_idle && $urandom_range(99) < 26) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
        end
        it.req_type = rt;
        it.vertex = 10'(v);
        it.side = s;
        it.gain_value = 8'(g);
        req_ch.valid <= 1;
        req_ch.data <= it;
        do @(posedge i_clk); while (!req_ch.ready);
        table_mirror.note_request(it);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 0;
        while (table_mirror.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // random request biased toward vertices already in the table
    task automatic random_request();
        int pick, v, g;
        bit s;
        pick = $urandom_range(99);
        s = $urandom_range(1);
        g = $urandom_range(255);
        if (active_pool.size() != 0 && $urandom_range(3) != 0)
            v = active_pool[$urandom_range(active_pool.size()-1)];
        else
            v = $urandom_range(NV-1);
        if (pick < 30) begin
            if (active_pool.size() < 40) active_pool.push_back(v);
            send_request(REQ_INSERT, v, s, $urandom_range(1) ? g : $urandom_range(80) - 40);
        end else if (pick < 55) send_request(REQ_UPDATE, v, s, $urandom_range(20) - 10);
        else if (pick < 75) send_request(REQ_POP, $urandom_range(NV-1), s, g);
        else if (pick < 85) send_request(REQ_ERASE, v, s, g);
        else if (pick < 93) send_request(REQ_LOCK, v, s, g);
        else if (pick < 96) begin
            t_req junk;
            junk = t_req'($urandom_range(7, 5));
            send_request(junk, v, s, g);
        end else send_request(REQ_INSERT, 0, s, g);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty pops, extremes, saturation, special cases
        send_request(REQ_POP, 0, 0, 0);
        send_request(REQ_POP, 0, 1, 0);
        send_request(REQ_INSERT, 1023, 0, 127);
        send_request(REQ_INSERT, 1, 1, -128);
        send_request(REQ_INSERT, 2, 1, -1);
        send_request(REQ_INSERT, 3, 1, -1);
        send_request(REQ_INSERT, 3, 0, 5);
        send_request(REQ_UPDATE, 2, 0, 127);
        send_request(REQ_UPDATE, 1, 1, 1);
        send_request(REQ_LOCK, 1, 0, 0);
        send_request(REQ_UPDATE, 1, 1, 1);
        send_request(REQ_ERASE, 1, 1, 0);
        send_request(REQ_ERASE, 500, 0, 0);
        send_request(REQ_ERASE, 3, 1, 0);
        send_request(REQ_INSERT, 0, 0, 3);
        send_request(t_req'(3'd7), 5, 1, 0);
        send_request(REQ_LOCK, 0, 0, 0);
        send_request(REQ_INSERT, 1, 1, 0);
        send_request(REQ_POP, 0, 0, 0);
        send_request(REQ_POP, 0, 0, 0);
        send_request(REQ_POP, 0, 1, 0);
        send_request(REQ_POP, 0, 1, 0);
        // sender holds off until the table has answered everything
        wait_drained();
        for (int i = 0; i < 1700; i++) begin
            no_idle = (i >= 600 && i < 800);
            random_request();
        end
        no_idle = 0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (table_mirror.mismatches == 0 && table_mirror.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #50000000;
        $display("tb: failure");
        $finish;
    end
endmodule

FILE: sim.f
design/fgbt_pkg.sv
design/fgbt_if.sv
design/fm_gain_bucket_table_unit.sv
verif/fm_gain_bucket_table_unit_tb.sv
